>>> rtl/core/triangle_plane_slicer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triangle plane slicer
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_SLICER_UNIT_DEFINES_SVH
`define TRIANGLE_PLANE_SLICER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPS_ASSERT_NOW(label, ante, cons)
`define TPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/tps_pkg.sv
// ---------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the triangle plane slicer.
// ---------------------------------------------------------------------------
package tps_pkg;

    localparam int COORD_W  = 32;
    localparam int LANES    = 4;
    localparam int DIV_STEP = 2;
    localparam int DIV_STG  = COORD_W / DIV_STEP;
    // three front stages, one multiply, divider stages, one output stage
    localparam int NSTG     = DIV_STG + 5;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
        logic signed [COORD_W-1:0] plane_z;
    } t_in_beat;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_out_beat;

    // unsigned operands of one multiply-divide lane
    typedef struct packed {
        logic [COORD_W-1:0] mn;
        logic [COORD_W-1:0] mdc;
        logic [COORD_W-1:0] mdz;
    } t_lane_req;

    // data that rides alongside the lanes
    typedef struct packed {
        logic                                hit;
        logic [LANES-1:0]                    neg;
        logic [LANES-1:0][COORD_W-1:0]       base;
    } t_side;

endpackage

>>> rtl/core/triangle_plane_slicer_unit.sv
// ---------------------------------------------------------------------------
// triangle_plane_slicer_unit
// Slices one triangle with a horizontal plane, one triangle per clock unless stalled.
//
//   channel | direction | handshake          | payload
//   in      | into      | i_valid / o_stall  | i_data (t_in_beat)
//   out     | out of    | o_valid / i_stall  | o_data (t_out_beat)
//
// The pipeline has NSTG stages: three front stages, one multiply, sixteen
// divider stages at two quotient bits each, one output register.
// One beat enters every cycle while o_stall is low; the divider depth sets the latency.
// Reset clears the stage valid bits only.
// A stall on the output fills empty stages first; input stalls once full.
// ---------------------------------------------------------------------------
`include "triangle_plane_slicer_unit_defines.svh"

module triangle_plane_slicer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tps_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output tps_pkg::t_out_beat  o_data
);
    import tps_pkg::*;

    logic [NSTG-1:0]               r_v;
    logic [NSTG-1:0]               en;
    t_lane_req [LANES-1:0]         req;
    t_side                         side;
    logic [LANES-1:0][COORD_W-1:0] quot;

    // a stage moves when empty or when the next one moves
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG-2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    tps_front u_front (
        .i_clk  (i_clk),
        .i_en   (en[2:0]),
        .i_data (i_data),
        .o_req  (req),
        .o_side (side)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        tps_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en[DIV_STG+3:3]),
            .i_req  (req[l]),
            .o_quot (quot[l])
        );
    end

    tps_back u_back (
        .i_clk  (i_clk),
        .i_en   (en[NSTG-1:3]),
        .i_side (side),
        .i_quot (quot),
        .o_data (o_data)
    );

    `TPS_ASSERT_NOW(a_miss_zero, o_valid && !o_data.hit, o_data.start_x == 0 && o_data.start_y == 0 && o_data.end_x == 0 && o_data.end_y == 0)
    `TPS_ASSERT_NOW(a_stall_full, o_stall, r_v[0] && r_v[NSTG-1] && i_stall)
    `TPS_ASSERT_NEXT(a_accept_fills, i_valid && !o_stall, r_v[0])
    `TPS_ASSERT_NEXT(a_out_held, o_valid && i_stall, o_valid)

endmodule

>>> rtl/core/tps_front.sv
// ---------------------------------------------------------------------------
// tps_front
// Edge crossing test, edge selection, differences and magnitudes.
// ---------------------------------------------------------------------------
module tps_front (
    input  logic                                   i_clk,
    input  logic [2:0]                             i_en,
    input  tps_pkg::t_in_beat                      i_data,
    output tps_pkg::t_lane_req [tps_pkg::LANES-1:0] o_req,
    output tps_pkg::t_side                         o_side
);
    import tps_pkg::*;

    logic [2:0]                r_a_cut;
    t_in_beat                  r_a_data;
    logic [2:0]                cut;

    logic                      r_b_hit;
    logic [1:0][COORD_W-1:0]   r_b_xa, r_b_ya;
    logic [1:0][COORD_W:0]     r_b_n, r_b_dz, r_b_dx, r_b_dy;
    logic [1:0][COORD_W-1:0]   n_b_xa, n_b_ya;
    logic [1:0][COORD_W:0]     n_b_n, n_b_dz, n_b_dx, n_b_dy;
    logic [2:0][COORD_W-1:0]   vx, vy, vz;

    t_lane_req [LANES-1:0]     r_c_req, n_c_req;
    t_side                     r_c_side, n_c_side;

    function automatic logic [COORD_W-1:0] mag33(input logic [COORD_W:0] v);
        logic [COORD_W:0] a;
        a = v[COORD_W] ? (~v + 1'b1) : v;
        return a[COORD_W-1:0];
    endfunction

    // test each edge for a strict crossing
    always_comb begin
        cut[0] = (i_data.v0_z < i_data.plane_z && i_data.plane_z < i_data.v1_z) ||
                 (i_data.v1_z < i_data.plane_z && i_data.plane_z < i_data.v0_z);
        cut[1] = (i_data.v1_z < i_data.plane_z && i_data.plane_z < i_data.v2_z) ||
                 (i_data.v2_z < i_data.plane_z && i_data.plane_z < i_data.v1_z);
        cut[2] = (i_data.v0_z < i_data.plane_z && i_data.plane_z < i_data.v2_z) ||
                 (i_data.v2_z < i_data.plane_z && i_data.plane_z < i_data.v0_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_cut  <= cut;
            r_a_data <= i_data;
        end
    end

    // pick the two crossed edges and form their differences
    always_comb begin
        logic [1:0] ea [2];
        logic [1:0] eb [2];
        vx[0] = r_a_data.v0_x; vy[0] = r_a_data.v0_y; vz[0] = r_a_data.v0_z;
        vx[1] = r_a_data.v1_x; vy[1] = r_a_data.v1_y; vz[1] = r_a_data.v1_z;
        vx[2] = r_a_data.v2_x; vy[2] = r_a_data.v2_y; vz[2] = r_a_data.v2_z;
        ea[0] = r_a_cut[0] ? 2'd0 : 2'd1;
        eb[0] = r_a_cut[0] ? 2'd1 : 2'd2;
        ea[1] = r_a_cut[2] ? 2'd0 : 2'd1;
        eb[1] = 2'd2;
        for (int k = 0; k < 2; k++) begin
            n_b_xa[k] = vx[ea[k]];
            n_b_ya[k] = vy[ea[k]];
            n_b_n[k]  = {r_a_data.plane_z[COORD_W-1], r_a_data.plane_z}
                        - {vz[ea[k]][COORD_W-1], vz[ea[k]]};
            n_b_dz[k] = {vz[eb[k]][COORD_W-1], vz[eb[k]]} - {vz[ea[k]][COORD_W-1], vz[ea[k]]};
            n_b_dx[k] = {vx[eb[k]][COORD_W-1], vx[eb[k]]} - {vx[ea[k]][COORD_W-1], vx[ea[k]]};
            n_b_dy[k] = {vy[eb[k]][COORD_W-1], vy[eb[k]]} - {vy[ea[k]][COORD_W-1], vy[ea[k]]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_hit <= (r_a_cut == 3'b011) || (r_a_cut == 3'b101) || (r_a_cut == 3'b110);
            r_b_xa  <= n_b_xa;
            r_b_ya  <= n_b_ya;
            r_b_n   <= n_b_n;
            r_b_dz  <= n_b_dz;
            r_b_dx  <= n_b_dx;
            r_b_dy  <= n_b_dy;
        end
    end

    // split into magnitudes and result sign per lane
    always_comb begin
        n_c_side.hit = r_b_hit;
        for (int k = 0; k < 2; k++) begin
            n_c_req[2*k].mn    = mag33(r_b_n[k]);
            n_c_req[2*k].mdc   = mag33(r_b_dx[k]);
            n_c_req[2*k].mdz   = mag33(r_b_dz[k]);
            n_c_req[2*k+1].mn  = mag33(r_b_n[k]);
            n_c_req[2*k+1].mdc = mag33(r_b_dy[k]);
            n_c_req[2*k+1].mdz = mag33(r_b_dz[k]);
            n_c_side.neg[2*k]   = r_b_n[k][COORD_W] ^ r_b_dx[k][COORD_W] ^ r_b_dz[k][COORD_W];
            n_c_side.neg[2*k+1] = r_b_n[k][COORD_W] ^ r_b_dy[k][COORD_W] ^ r_b_dz[k][COORD_W];
            n_c_side.base[2*k]   = r_b_xa[k];
            n_c_side.base[2*k+1] = r_b_ya[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_req  <= n_c_req;
            r_c_side <= n_c_side;
        end
    end

    assign o_req  = r_c_req;
    assign o_side = r_c_side;

endmodule

>>> rtl/core/tps_lane.sv
// ---------------------------------------------------------------------------
// tps_lane
// Pipelined multiply then restoring divide: floor(mn * mdc / mdz).
// ---------------------------------------------------------------------------
module tps_lane (
    input  logic                           i_clk,
    input  logic [tps_pkg::DIV_STG:0]      i_en,
    input  tps_pkg::t_lane_req             i_req,
    output logic [tps_pkg::COORD_W-1:0]    o_quot
);
    import tps_pkg::*;

    logic [2*COORD_W-1:0] r_prod;
    logic [2*COORD_W-1:0] r_st [DIV_STG];
    logic [COORD_W-1:0]   r_d  [DIV_STG];

    // DIV_STEP restoring steps on {remainder, dividend/quotient}
    function automatic logic [2*COORD_W-1:0] div_step(input logic [2*COORD_W-1:0] st,
                                                      input logic [COORD_W-1:0] d);
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] pq;
        logic [COORD_W:0]   t;
        rem = st[2*COORD_W-1:COORD_W];
        pq  = st[COORD_W-1:0];
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {rem, pq[COORD_W-1]};
            if (t >= {1'b0, d}) begin
                t  = t - {1'b0, d};
                pq = {pq[COORD_W-2:0], 1'b1};
            end else begin
                pq = {pq[COORD_W-2:0], 1'b0};
            end
            rem = t[COORD_W-1:0];
        end
        return {rem, pq};
    endfunction

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= i_req.mn * i_req.mdc;
            r_d[0] <= i_req.mdz;
        end
    end

    // divider stages
    for (genvar s = 0; s < DIV_STG; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en[s+1]) begin
                r_st[s] <= div_step((s == 0) ? r_prod : r_st[(s == 0) ? 0 : s-1], r_d[s]);
            end
        end

        // carry the divisor along to the next step
        if (s < DIV_STG-1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en[s+1]) begin
                    r_d[s+1] <= r_d[s];
                end
            end
        end
    end

    assign o_quot = r_st[DIV_STG-1][COORD_W-1:0];

endmodule

>>> rtl/core/tps_back.sv
// ---------------------------------------------------------------------------
// tps_back
// Side data delay line, sign and offset add, output register.
// ---------------------------------------------------------------------------
module tps_back (
    input  logic                                    i_clk,
    input  logic [tps_pkg::DIV_STG+1:0]             i_en,
    input  tps_pkg::t_side                          i_side,
    input  logic [tps_pkg::LANES-1:0][tps_pkg::COORD_W-1:0] i_quot,
    output tps_pkg::t_out_beat                      o_data
);
    import tps_pkg::*;

    t_side                         r_side [DIV_STG+1];
    t_out_beat                     r_out, n_out;
    logic [LANES-1:0][COORD_W-1:0] res;

    // delay side data to match the lanes
    for (genvar s = 0; s <= DIV_STG; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s-1];
            end
        end
    end

    // apply sign, add base, zero when no hit
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            res[l] = r_side[DIV_STG].base[l] +
                     (r_side[DIV_STG].neg[l] ? (~i_quot[l] + 1'b1) : i_quot[l]);
        end
        n_out.hit     = r_side[DIV_STG].hit;
        n_out.start_x = r_side[DIV_STG].hit ? res[0] : '0;
        n_out.start_y = r_side[DIV_STG].hit ? res[1] : '0;
        n_out.end_x   = r_side[DIV_STG].hit ? res[2] : '0;
        n_out.end_y   = r_side[DIV_STG].hit ? res[3] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STG+1]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule
